>>> rtl/core/fqdk_pkg.sv
// ----------------------------------------------------------------------------
// fqdk_pkg
// shared types, constants and slot arithmetic for the keyed fifo queue
// ----------------------------------------------------------------------------
package fqdk_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W       = 24;
  localparam int PAY_W       = 64;
  localparam int CNT_W       = 5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   idx_sum_t;
  typedef logic [OCC_W-1:0] occ_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0] pay_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_DEL = 2'd2,
    ACT_DUP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // one stored entry
  typedef struct packed {
    key_t key;
    pay_t pay;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // one result transaction
  typedef struct packed {
    status_e status;
    logic    match;
    key_t    key;
    pay_t    pay;
    cnt_t    count;
  } res_t;

  // request to the two entry banks
  typedef struct packed {
    logic [1:0] we;
    idx_t       waddr;
    ent_t       wdata;
    idx_t       raddr;
  } ram_req_t;

  // (head + off) wrapped at the queue depth, both operands below the depth
  function automatic idx_t slot_of(idx_t head, idx_t off);
    idx_sum_t s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= idx_sum_t'(QUEUE_DEPTH)) begin
      s = s - idx_sum_t'(QUEUE_DEPTH);
    end
    return idx_t'(s);
  endfunction

endpackage

>>> rtl/core/fqdk_ram.sv
// ----------------------------------------------------------------------------
// fqdk_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fqdk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fqdk_ctrl.sv
// ----------------------------------------------------------------------------
// fqdk_ctrl
// sequencer: queue pointers, bank select and the entry walk with one comparator
// ----------------------------------------------------------------------------
module fqdk_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  output logic               busy_o,
  input  fqdk_pkg::action_e  action_i,
  input  fqdk_pkg::key_t     key_i,
  input  fqdk_pkg::pay_t     pay_i,
  output fqdk_pkg::ram_req_t ram_o,
  input  fqdk_pkg::ent_t     rdata0_i,
  input  fqdk_pkg::ent_t     rdata1_i,
  output logic               res_vld_o,
  output fqdk_pkg::res_t     res_o,
  input  logic               out_free_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  fqdk_pkg::idx_t    head_q, head_d;
  fqdk_pkg::occ_t    occ_q, occ_d;
  logic              bank_q, bank_d;
  fqdk_pkg::action_e act_q, act_d;
  fqdk_pkg::key_t    key_q, key_d;
  fqdk_pkg::occ_t    idx_q, idx_d;
  fqdk_pkg::occ_t    lim_q, lim_d;
  logic              pend_q, pend_d;
  fqdk_pkg::occ_t    kept_q, kept_d;
  logic              found_q, found_d;
  fqdk_pkg::res_t    res_q, res_d;

  logic              issue;
  logic              hit;
  fqdk_pkg::ent_t    rent;

  assign rent  = bank_q ? rdata1_i : rdata0_i;
  assign hit   = (rent.key == key_q);
  assign issue = (idx_q != lim_q);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    occ_d   = occ_q;
    bank_d  = bank_q;
    act_d   = act_q;
    key_d   = key_q;
    idx_d   = idx_q;
    lim_d   = lim_q;
    pend_d  = pend_q;
    kept_d  = kept_q;
    found_d = found_q;
    res_d   = res_q;

    ram_o.we    = 2'b00;
    ram_o.waddr = fqdk_pkg::slot_of(head_q, fqdk_pkg::idx_t'(occ_q));
    ram_o.wdata.key = key_i;
    ram_o.wdata.pay = pay_i;
    ram_o.raddr = fqdk_pkg::slot_of(head_q, fqdk_pkg::idx_t'(idx_q));

    case (state_q)
      S_IDLE: begin
        if (acc_i) begin
          act_d        = action_i;
          key_d        = key_i;
          idx_d        = '0;
          pend_d       = 1'b0;
          kept_d       = '0;
          found_d      = 1'b0;
          lim_d        = occ_q;
          res_d.status = fqdk_pkg::ST_OK;
          res_d.match  = 1'b0;
          res_d.key    = '0;
          res_d.pay    = '0;
          res_d.count  = fqdk_pkg::cnt_t'(occ_q);
          state_d      = S_DONE;
          case (action_i)
            fqdk_pkg::ACT_ENQ: begin
              if (occ_q == fqdk_pkg::occ_t'(fqdk_pkg::QUEUE_DEPTH)) begin
                res_d.status = fqdk_pkg::ST_FULL;
              end else begin
                ram_o.we[bank_q] = 1'b1;
                occ_d            = occ_q + fqdk_pkg::occ_t'(1);
                res_d.count      = fqdk_pkg::cnt_t'(occ_q + fqdk_pkg::occ_t'(1));
              end
            end
            fqdk_pkg::ACT_DEQ: begin
              if (occ_q == '0) begin
                res_d.status = fqdk_pkg::ST_EMPTY;
              end else begin
                lim_d   = fqdk_pkg::occ_t'(1);
                state_d = S_SCAN;
              end
            end
            fqdk_pkg::ACT_DEL: begin
              if (occ_q == '0) begin
                res_d.status = fqdk_pkg::ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              if (occ_q != '0) begin
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // read of entry idx is issued here, compared in the next cycle
        if (issue) begin
          idx_d = idx_q + fqdk_pkg::occ_t'(1);
        end
        pend_d = issue;

        if (pend_q) begin
          case (act_q)
            fqdk_pkg::ACT_DEQ: begin
              res_d.key = rent.key;
              res_d.pay = rent.pay;
            end
            fqdk_pkg::ACT_DEL: begin
              if (hit) begin
                found_d = 1'b1;
              end else begin
                // survivors are packed from slot 0 of the other bank
                ram_o.we[~bank_q] = 1'b1;
                ram_o.waddr       = fqdk_pkg::idx_t'(kept_q);
                ram_o.wdata       = rent;
                kept_d            = kept_q + fqdk_pkg::occ_t'(1);
              end
            end
            default: begin
              if (hit) begin
                found_d = 1'b1;
              end
            end
          endcase
        end

        if (!issue && !pend_q) begin
          state_d = S_DONE;
          case (act_q)
            fqdk_pkg::ACT_DEQ: begin
              occ_d       = occ_q - fqdk_pkg::occ_t'(1);
              head_d      = (occ_q == fqdk_pkg::occ_t'(1)) ? '0 :
                            fqdk_pkg::slot_of(head_q, fqdk_pkg::idx_t'(1));
              res_d.count = fqdk_pkg::cnt_t'(occ_q - fqdk_pkg::occ_t'(1));
            end
            fqdk_pkg::ACT_DEL: begin
              if (found_q) begin
                bank_d      = ~bank_q;
                head_d      = '0;
                occ_d       = kept_q;
                res_d.count = fqdk_pkg::cnt_t'(kept_q);
              end else begin
                res_d.status = fqdk_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              res_d.match = found_q;
            end
          endcase
        end
      end

      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      occ_q   <= '0;
      bank_q  <= 1'b0;
      act_q   <= fqdk_pkg::ACT_ENQ;
      key_q   <= '0;
      idx_q   <= '0;
      lim_q   <= '0;
      pend_q  <= 1'b0;
      kept_q  <= '0;
      found_q <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
      bank_q  <= bank_d;
      act_q   <= act_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
      lim_q   <= lim_d;
      pend_q  <= pend_d;
      kept_q  <= kept_d;
      found_q <= found_d;
      res_q   <= res_d;
    end
  end

  assign busy_o    = (state_q != S_IDLE);
  assign res_vld_o = (state_q == S_DONE);
  assign res_o     = res_q;

endmodule

>>> rtl/core/fifo_queue_with_delete_by_key.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_key
// circular fifo of keyed entries with dequeue, delete by key and key search
// ----------------------------------------------------------------------------
// every input transaction gives exactly one result transaction. enqueue writes
// its entry without a walk, and an action that finds the queue full or empty
// also goes straight to its result. dequeue reads the head entry; delete and
// duplicate check walk all stored entries (up to the depth of 16). the walk
// reads one entry per cycle through the single read port of the active bank
// and checks it with one key comparator.
// the block takes one input transaction at a time; in_stall_o stays high
// until its result has moved into the output register, which may still hold
// the previous result while the next transaction is taken. entries live in
// two banks: delete copies the surviving entries in order into the other bank
// and then swaps banks, so a delete that finds nothing leaves the queue as is.
// entry memories need no clearing after reset, only stored entries are read.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_by_key (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [23:0] request_key_i,
  input  logic [63:0] payload_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        match_found_o,
  output logic [23:0] out_key_o,
  output logic [63:0] payload_out_o,
  output logic [4:0]  entry_count_o
);

  logic               busy;
  logic               acc;
  logic               res_vld;
  logic               out_free;
  fqdk_pkg::res_t     res;
  fqdk_pkg::ram_req_t ram_req;
  logic [fqdk_pkg::ENT_W-1:0] rdata0;
  logic [fqdk_pkg::ENT_W-1:0] rdata1;

  logic               out_valid_q;
  fqdk_pkg::res_t     out_q;

  // input transaction taken only while the sequencer is idle
  assign in_stall_o = busy;
  assign acc        = in_valid_i && !busy;

  // output register frees when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  fqdk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .busy_o     (busy),
    .action_i   (fqdk_pkg::action_e'(action_i)),
    .key_i      (request_key_i),
    .pay_i      (payload_in_i),
    .ram_o      (ram_req),
    .rdata0_i   (fqdk_pkg::ent_t'(rdata0)),
    .rdata1_i   (fqdk_pkg::ent_t'(rdata1)),
    .res_vld_o  (res_vld),
    .res_o      (res),
    .out_free_i (out_free)
  );

  // two entry banks, swapped after a delete that removes something
  fqdk_ram #(
    .Width (fqdk_pkg::ENT_W),
    .Depth (fqdk_pkg::QUEUE_DEPTH)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (ram_req.we[0]),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata0)
  );

  fqdk_ram #(
    .Width (fqdk_pkg::ENT_W),
    .Depth (fqdk_pkg::QUEUE_DEPTH)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (ram_req.we[1]),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata1)
  );

  // output register, loaded when the sequencer finishes and the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= res_vld;
        if (res_vld) begin
          out_q <= res;
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign match_found_o = out_q.match;
  assign out_key_o     = out_q.key;
  assign payload_out_o = out_q.pay;
  assign entry_count_o = out_q.count;

endmodule
